// ===== hdl/crs_pkg.sv =====
// Shared constants for the Catmull-Rom segment evaluator.
package crs_pkg;

    localparam int GUARD_BITS = 8;
    localparam int TAN_EXTRA  = 4;
    localparam int ACC_MARGIN = 8;

endpackage

// ===== hdl/crs_in_if.sv =====
// Request channel carrying four control coordinates and the segment parameter.
interface crs_in_if #(
    parameter int COORD_WIDTH = 32,
    parameter int PARAM_BITS  = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] ctrl_before;
    logic signed [COORD_WIDTH-1:0] ctrl_start;
    logic signed [COORD_WIDTH-1:0] ctrl_end;
    logic signed [COORD_WIDTH-1:0] ctrl_after;
    logic        [PARAM_BITS:0]    param_frac;

    modport source (
        output valid, ctrl_before, ctrl_start, ctrl_end, ctrl_after, param_frac,
        input  ready
    );
    modport sink (
        input  valid, ctrl_before, ctrl_start, ctrl_end, ctrl_after, param_frac,
        output ready
    );
endinterface

// ===== hdl/crs_out_if.sv =====
// Result channel carrying the interpolated coordinate and its tangent.
interface crs_out_if import crs_pkg::*; #(
    parameter int COORD_WIDTH = 32
) ();
    logic                                    valid;
    logic                                    ready;
    logic signed [COORD_WIDTH-1:0]           position_coord;
    logic signed [COORD_WIDTH+TAN_EXTRA-1:0] tangent_coord;

    modport source (
        output valid, position_coord, tangent_coord,
        input  ready
    );
    modport sink (
        input  valid, position_coord, tangent_coord,
        output ready
    );
endinterface

// ===== hdl/catmull_rom_spline_eval.sv =====
// Pipelined uniform Catmull-Rom segment evaluator for one coordinate axis.
//
//   channel | dir | handshake         | payload
//   i_in    | in  | valid/ready       | ctrl_before, ctrl_start, ctrl_end, ctrl_after,
//           |     |                   | param_frac
//   o_out   | out | valid/ready       | position_coord, tangent_coord
//
// One request per cycle unless o_out stalls; each result passes r_s1 to r_s8 in turn.
// The eight stages are coefficients, then three Horner multiply/add pairs, then
// rounding and saturation; the position chain sets the latency.
// i_rst_n (synchronous, active low) clears the stage valid bits only.
// A stall on o_out freezes every stage; i_in.ready drops only while the output
// stage holds a result that is not taken.
module catmull_rom_spline_eval import crs_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int PARAM_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    crs_in_if.sink     i_in,
    crs_out_if.source  o_out
);

    localparam int PW     = PARAM_BITS + 1;
    localparam int ACC_W  = COORD_WIDTH + GUARD_BITS + ACC_MARGIN;
    localparam int PROD_W = ACC_W + PW;
    localparam int TAN_W  = COORD_WIDTH + TAN_EXTRA;
    localparam int STAGES = 8;

    localparam logic [PW-1:0]     T_ONE = {1'b1, {PARAM_BITS{1'b0}}};
    localparam logic [PROD_W-1:0] HALF  =
        {{(PROD_W-PARAM_BITS){1'b0}}, 1'b1, {(PARAM_BITS-1){1'b0}}};

    function automatic logic [ACC_W-1:0] f_mag(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] u;
        u = v;
        return v[ACC_W-1] ? (~u + 1'b1) : u;
    endfunction

    function automatic logic signed [ACC_W-1:0] f_unprod(input logic [PROD_W-1:0] p,
                                                         input logic neg);
        logic [PROD_W-1:0]       q;
        logic signed [ACC_W-1:0] s;
        q = (p + HALF) >> PARAM_BITS;
        s = signed'(q[ACC_W-1:0]);
        return neg ? -s : s;
    endfunction

    function automatic logic signed [ACC_W-1:0] f_round_sat(
        input logic signed [ACC_W-1:0] v, input int w);
        logic [ACC_W-1:0]        q;
        logic signed [ACC_W-1:0] s;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        q  = (f_mag(v) + (ACC_W'(1) << GUARD_BITS)) >> (GUARD_BITS + 1);
        s  = v[ACC_W-1] ? -signed'(q) : signed'(q);
        hi = signed'((ACC_W'(1) << (w - 1)) - ACC_W'(1));
        lo = ~hi;
        if (s > hi) begin
            return hi;
        end else if (s < lo) begin
            return lo;
        end
        return s;
    endfunction

    logic                    w_adv;
    logic [STAGES-1:0]       r_vld;

    logic signed [ACC_W-1:0] n_p0, n_p1, n_p2, n_p3;
    logic [PW-1:0]           n_t;

    logic signed [ACC_W-1:0] r_s1_k0, r_s1_k1, r_s1_k2, r_s1_k3, r_s1_k3x3;
    logic [PW-1:0]           r_s1_t;

    logic [PROD_W-1:0]       r_s2_pp, r_s2_tp;
    logic                    r_s2_pn, r_s2_tn;
    logic signed [ACC_W-1:0] r_s2_k0, r_s2_k1, r_s2_k2;
    logic [PW-1:0]           r_s2_t;

    logic signed [ACC_W-1:0] r_s3_ap, r_s3_at, r_s3_k0, r_s3_k1;
    logic [PW-1:0]           r_s3_t;

    logic [PROD_W-1:0]       r_s4_pp, r_s4_tp;
    logic                    r_s4_pn, r_s4_tn;
    logic signed [ACC_W-1:0] r_s4_k0, r_s4_k1;
    logic [PW-1:0]           r_s4_t;

    logic signed [ACC_W-1:0] r_s5_ap, r_s5_at, r_s5_k0;
    logic [PW-1:0]           r_s5_t;

    logic [PROD_W-1:0]       r_s6_pp;
    logic                    r_s6_pn;
    logic signed [ACC_W-1:0] r_s6_k0;
    logic signed [TAN_W-1:0] r_s6_tan;

    logic signed [ACC_W-1:0] r_s7_ap;
    logic signed [TAN_W-1:0] r_s7_tan;

    logic signed [COORD_WIDTH-1:0] r_s8_pos;
    logic signed [TAN_W-1:0]       r_s8_tan;

    assign w_adv      = !r_vld[STAGES-1] || o_out.ready;
    assign i_in.ready = w_adv;

    assign n_p0 = ACC_W'(i_in.ctrl_before);
    assign n_p1 = ACC_W'(i_in.ctrl_start);
    assign n_p2 = ACC_W'(i_in.ctrl_end);
    assign n_p3 = ACC_W'(i_in.ctrl_after);
    assign n_t  = (i_in.param_frac > T_ONE) ? T_ONE : i_in.param_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[STAGES-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_k0   <= (n_p1 <<< 1) <<< GUARD_BITS;
            r_s1_k1   <= (n_p2 - n_p0) <<< GUARD_BITS;
            r_s1_k2   <= ((n_p0 <<< 1) - ((n_p1 <<< 2) + n_p1) + (n_p2 <<< 2) - n_p3)
                         <<< GUARD_BITS;
            r_s1_k3   <= (n_p3 - n_p0 + ((n_p1 <<< 1) + n_p1) - ((n_p2 <<< 1) + n_p2))
                         <<< GUARD_BITS;
            r_s1_k3x3 <= (((n_p3 - n_p0) <<< 1) + (n_p3 - n_p0)
                         + ((n_p1 - n_p2) <<< 3) + (n_p1 - n_p2)) <<< GUARD_BITS;
            r_s1_t    <= n_t;

            r_s2_pp <= PROD_W'(f_mag(r_s1_k3)) * PROD_W'(r_s1_t);
            r_s2_pn <= r_s1_k3[ACC_W-1];
            r_s2_tp <= PROD_W'(f_mag(r_s1_k3x3)) * PROD_W'(r_s1_t);
            r_s2_tn <= r_s1_k3x3[ACC_W-1];
            r_s2_k0 <= r_s1_k0;
            r_s2_k1 <= r_s1_k1;
            r_s2_k2 <= r_s1_k2;
            r_s2_t  <= r_s1_t;

            r_s3_ap <= f_unprod(r_s2_pp, r_s2_pn) + r_s2_k2;
            r_s3_at <= f_unprod(r_s2_tp, r_s2_tn) + (r_s2_k2 <<< 1);
            r_s3_k0 <= r_s2_k0;
            r_s3_k1 <= r_s2_k1;
            r_s3_t  <= r_s2_t;

            r_s4_pp <= PROD_W'(f_mag(r_s3_ap)) * PROD_W'(r_s3_t);
            r_s4_pn <= r_s3_ap[ACC_W-1];
            r_s4_tp <= PROD_W'(f_mag(r_s3_at)) * PROD_W'(r_s3_t);
            r_s4_tn <= r_s3_at[ACC_W-1];
            r_s4_k0 <= r_s3_k0;
            r_s4_k1 <= r_s3_k1;
            r_s4_t  <= r_s3_t;

            r_s5_ap <= f_unprod(r_s4_pp, r_s4_pn) + r_s4_k1;
            r_s5_at <= f_unprod(r_s4_tp, r_s4_tn) + r_s4_k1;
            r_s5_k0 <= r_s4_k0;
            r_s5_t  <= r_s4_t;

            r_s6_pp  <= PROD_W'(f_mag(r_s5_ap)) * PROD_W'(r_s5_t);
            r_s6_pn  <= r_s5_ap[ACC_W-1];
            r_s6_k0  <= r_s5_k0;
            r_s6_tan <= TAN_W'(f_round_sat(r_s5_at, TAN_W));

            r_s7_ap  <= f_unprod(r_s6_pp, r_s6_pn) + r_s6_k0;
            r_s7_tan <= r_s6_tan;

            r_s8_pos <= COORD_WIDTH'(f_round_sat(r_s7_ap, COORD_WIDTH));
            r_s8_tan <= r_s7_tan;
        end
    end

    assign o_out.valid          = r_vld[STAGES-1];
    assign o_out.position_coord = r_s8_pos;
    assign o_out.tangent_coord  = r_s8_tan;

endmodule
